>>> sv/gas_pkg.sv
// Package for the greedy activity selector.
// Holds sizes, the controller state type and the time type; no dependencies.
`default_nettype none
package gas_pkg;
	localparam int MAX_ACT = 64;
	localparam int IDX_W   = $clog2(MAX_ACT);
	localparam int CNT_W   = IDX_W + 1;
	localparam int TIME_W  = 16;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [8:0] {
		ST_LOAD   = 9'b000000001,
		ST_KEY_RD = 9'b000000010,
		ST_KEY    = 9'b000000100,
		ST_SH_RD  = 9'b000001000,
		ST_SH_CMP = 9'b000010000,
		ST_SC_ORD = 9'b000100000,
		ST_SC_DAT = 9'b001000000,
		ST_SC_EVL = 9'b010000000,
		ST_FLUSH  = 9'b100000000
	} state_t;
endpackage
`default_nettype wire

>>> sv/gas_if.sv
// Request channel interfaces for activities in and picks out.
// Depends on gas_pkg for the time and count types.
`default_nettype none
interface gas_act_if import gas_pkg::*; ();
	logic  valid;
	logic  ready;
	time_t start_time;
	time_t end_time;
	logic  last_item;
	modport source (output valid, start_time, end_time, last_item, input ready);
	modport sink (input valid, start_time, end_time, last_item, output ready);
endinterface

interface gas_pick_if import gas_pkg::*; ();
	logic  valid;
	logic  ready;
	time_t pick_start;
	time_t pick_end;
	cnt_t  sorted_position;
	cnt_t  pick_number;
	logic  last_result;
	modport source (output valid, pick_start, pick_end, sorted_position, pick_number,
		last_result, input ready);
	modport sink (input valid, pick_start, pick_end, sorted_position, pick_number,
		last_result, output ready);
endinterface
`default_nettype wire

>>> sv/greedy_activity_selector.sv
// Greedy activity selector: loads a batch, insertion-sorts it in memory, scans it.
// Loading accepts one request per cycle. After the last request the insertion sort
// shifts each activity into place, one read-compare-write per shift through the order
// memory; then the scan reads the order, reads the data and evaluates each activity,
// ends with a flush of the last pick and waits on output stalls. Reset clears control
// state only; the memories need no clearing. Depends on gas_pkg and gas_if.
`default_nettype none
module greedy_activity_selector import gas_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	gas_act_if.sink     act,
	gas_pick_if.source  pick
);
	// Storage.
	time_t start_mem [MAX_ACT];
	time_t end_mem   [MAX_ACT];
	idx_t  order_mem [MAX_ACT];
	time_t skey_mem  [MAX_ACT];

	state_t state_q;
	logic   mode_q, bmode_q;
	cnt_t   count_q, n_q, i_q, p_q, picks_q;
	idx_t   j_q;
	time_t  key_q, bound_q;
	time_t  start_rd_q, end_rd_q, skey_rd_q;
	idx_t   ord_rd_q;

	// Pending pick, emitted once the next one is known or the scan ends.
	logic  pend_q;
	time_t pend_start_q, pend_end_q;
	cnt_t  pend_pos_q, pend_num_q;

	// Output register.
	logic  ov_q;
	time_t o_start_q, o_end_q;
	cnt_t  o_pos_q, o_num_q;
	logic  o_last_q;

	logic  in_acc, out_free, sort_st, take, ord_we, out_load;
	idx_t  data_addr, ord_addr, scan_idx, ord_wa, ord_wd;
	time_t skey_wd;
	cnt_t  n_last;

	assign in_acc   = act.valid && act.ready;
	assign out_free = !ov_q || pick.ready;
	assign act.ready = (state_q == ST_LOAD);
	assign sort_st  = (state_q == ST_KEY_RD) || (state_q == ST_KEY) ||
		(state_q == ST_SH_RD) || (state_q == ST_SH_CMP);
	assign n_last   = n_q - cnt_t'(1);
	assign scan_idx = bmode_q ? idx_t'(n_last - p_q) : p_q[IDX_W-1:0];

	// The output register loads when a pending pick moves out.
	assign out_load = ((state_q == ST_SC_EVL) && take && pend_q && out_free) ||
		((state_q == ST_FLUSH) && out_free);

	// Read address selection.
	assign data_addr = sort_st ? i_q[IDX_W-1:0] : ord_rd_q;
	assign ord_addr  = sort_st ? (j_q - idx_t'(1)) : scan_idx;

	// Scan decision on the activity just read.
	always_comb begin
		if (p_q == '0) begin
			take = 1'b1;
		end else if (bmode_q) begin
			take = (end_rd_q <= bound_q);
		end else begin
			take = (start_rd_q >= bound_q);
		end
	end

	// Sort write port: shift an entry up or drop the current one in place.
	always_comb begin
		ord_we  = 1'b0;
		ord_wa  = j_q;
		ord_wd  = i_q[IDX_W-1:0];
		skey_wd = key_q;
		if (state_q == ST_SH_RD && j_q == '0) begin
			ord_we = 1'b1;
		end else if (state_q == ST_SH_CMP) begin
			ord_we = 1'b1;
			if (skey_rd_q > key_q) begin
				ord_wd  = ord_rd_q;
				skey_wd = skey_rd_q;
			end
		end
	end

	// Data memories: written on load, read for keys and scan.
	always_ff @(posedge clk) begin
		if (in_acc && count_q < cnt_t'(MAX_ACT)) begin
			start_mem[count_q[IDX_W-1:0]] <= act.start_time;
			end_mem[count_q[IDX_W-1:0]]   <= act.end_time;
		end
		start_rd_q <= start_mem[data_addr];
		end_rd_q   <= end_mem[data_addr];
	end

	// Order and sorted key memories.
	always_ff @(posedge clk) begin
		if (ord_we) begin
			order_mem[ord_wa] <= ord_wd;
			skey_mem[ord_wa]  <= skey_wd;
		end
		ord_rd_q  <= order_mem[ord_addr];
		skey_rd_q <= skey_mem[ord_addr];
	end

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
			picks_q <= '0;
			bound_q <= '0;
			bmode_q <= 1'b0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= out_load || (ov_q && !pick.ready);
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (act.last_item) begin
							n_q     <= (count_q < cnt_t'(MAX_ACT)) ?
								count_q + cnt_t'(1) : count_q;
							count_q <= '0;
							picks_q <= '0;
							bmode_q <= mode_q;
							i_q     <= '0;
							state_q <= ST_KEY_RD;
						end else if (count_q < cnt_t'(MAX_ACT)) begin
							count_q <= count_q + cnt_t'(1);
						end
					end
				end
				ST_KEY_RD: begin
					state_q <= ST_KEY;
				end
				ST_KEY: begin
					key_q   <= bmode_q ? start_rd_q : end_rd_q;
					j_q     <= i_q[IDX_W-1:0];
					state_q <= ST_SH_RD;
				end
				ST_SH_RD: begin
					if (j_q == '0) begin
						i_q     <= i_q + cnt_t'(1);
						p_q     <= '0;
						state_q <= (i_q + cnt_t'(1) == n_q) ? ST_SC_ORD : ST_KEY_RD;
					end else begin
						state_q <= ST_SH_CMP;
					end
				end
				ST_SH_CMP: begin
					if (skey_rd_q > key_q) begin
						j_q     <= j_q - idx_t'(1);
						state_q <= ST_SH_RD;
					end else begin
						i_q     <= i_q + cnt_t'(1);
						p_q     <= '0;
						state_q <= (i_q + cnt_t'(1) == n_q) ? ST_SC_ORD : ST_KEY_RD;
					end
				end
				ST_SC_ORD: begin
					state_q <= ST_SC_DAT;
				end
				ST_SC_DAT: begin
					state_q <= ST_SC_EVL;
				end
				ST_SC_EVL: begin
					if (!(take && pend_q && !out_free)) begin
						if (take) begin
							if (pend_q) begin
								o_start_q <= pend_start_q;
								o_end_q   <= pend_end_q;
								o_pos_q   <= pend_pos_q;
								o_num_q   <= pend_num_q;
								o_last_q  <= 1'b0;
							end
							pend_q       <= 1'b1;
							pend_start_q <= start_rd_q;
							pend_end_q   <= end_rd_q;
							pend_pos_q   <= p_q + cnt_t'(1);
							pend_num_q   <= picks_q + cnt_t'(1);
							picks_q      <= picks_q + cnt_t'(1);
							bound_q      <= bmode_q ? start_rd_q : end_rd_q;
						end
						p_q     <= p_q + cnt_t'(1);
						state_q <= (p_q + cnt_t'(1) == n_q) ? ST_FLUSH : ST_SC_ORD;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						o_start_q <= pend_start_q;
						o_end_q   <= pend_end_q;
						o_pos_q   <= pend_pos_q;
						o_num_q   <= pend_num_q;
						o_last_q  <= 1'b1;
						pend_q    <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign pick.valid           = ov_q;
	assign pick.pick_start      = o_start_q;
	assign pick.pick_end        = o_end_q;
	assign pick.sorted_position = o_pos_q;
	assign pick.pick_number     = o_num_q;
	assign pick.last_result     = o_last_q;

	// The load counter never passes the batch capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_ACT)) else $error("load count overflow");

	// Picks never outnumber scanned positions.
	a_picks_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		picks_q <= p_q || sort_st || state_q == ST_LOAD) else $error("pick count too large");

	// A scan always ends with a pending pick to flush.
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> pend_q) else $error("flush without pick");
endmodule
`default_nettype wire
